>>> hw/rtl/msw_pkg.sv
// Shared types, constants and the quarter-wave sine table of the waveform generator.
package msw_pkg;

   localparam int SAMPLE_LENGTH    = 4096;
   localparam int SINE_TABLE_DEPTH = 256;

   localparam int SAMPLE_IDX_W = $clog2(SAMPLE_LENGTH);
   localparam int SINE_IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
   localparam logic [16:0] FULL_Q16    = 17'h10000;
   localparam logic [16:0] TRI_FRESH   = 17'h1FFFF;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      SHAPE_SINE = 2'd0,
      SHAPE_SAW  = 2'd1,
      SHAPE_TRI  = 2'd2,
      SHAPE_NONE = 2'd3
   } shape_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WAVE_SHAPE  = 3'd0,
      CSR_AMPLITUDE   = 3'd1,
      CSR_PHASE_STEP  = 3'd2,
      CSR_SAW_LENGTH  = 3'd3,
      CSR_HALF_PERIOD = 3'd4,
      CSR_SLOPE       = 3'd5
   } csr_index_type;

   typedef struct packed {
      shape_type   wave_shape;
      logic [16:0] amplitude;
      logic [31:0] phase_step;
      logic [15:0] saw_length;
      logic [15:0] half_period;
      logic [31:0] slope;
   } msw_cfg_type;

   typedef logic [16:0] sine_rom_type [SINE_TABLE_DEPTH + 1];

   // Restoring long division, evaluated only while the sine table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Entry k is sin(pi/2 * k / depth) in unsigned Q1.16, from a nine-term
   // Taylor series in Q30, rounded to Q16 and clamped to full scale.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  r;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = div_u64(64'(k) * PI_HALF_Q30, 64'(SINE_TABLE_DEPTH));
         term = x;
         sum  = x;
         for (int n = 1; n <= 8; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = div_u64(term, 64'(2 * n) * 64'(2 * n + 1));
            if ((n & 1) != 0) begin
               sum = (sum > term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         r      = (sum + 64'd8192) >> 14;
         rom[k] = (r > 64'(FULL_Q16)) ? FULL_Q16 : r[16:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

>>> hw/rtl/msw_regs.sv
// Configuration register file of the waveform generator.
module msw_regs
   import msw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output msw_cfg_type            cfg
);

   msw_cfg_type cfg_ff;
   msw_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WAVE_SHAPE:  cfg_in.wave_shape  = shape_type'(csr_data[1:0]);
            CSR_AMPLITUDE:   cfg_in.amplitude   = csr_data[16:0];
            CSR_PHASE_STEP:  cfg_in.phase_step  = csr_data[31:0];
            CSR_SAW_LENGTH:  cfg_in.saw_length  = csr_data[15:0];
            CSR_HALF_PERIOD: cfg_in.half_period = csr_data[15:0];
            CSR_SLOPE:       cfg_in.slope       = csr_data[31:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{wave_shape: SHAPE_SINE, amplitude: 17'd0, phase_step: 32'd0,
                     saw_length: 16'd1, half_period: 16'd0, slope: 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/multi_shape_waveform_generator_top.sv
// Multi-shape waveform generator: top level with state update and sample pipeline.
//
// Every transfer on the req_ channel is one tick and produces exactly one
// transfer on the rsp_ channel carrying the next sample of the selected wave
// (sine from a quarter-wave table, sawtooth or triangle) together with a flag
// marking the last sample of each block of SAMPLE_LENGTH samples. The block
// accepts one tick per clock cycle unless the pipeline is full and stalled, set
// by the four pipeline registers that each hand on one sample per cycle, and a
// sample is presented on rsp_ once its tick has passed all four registers:
// the phase accumulator and the counters advance in the accepting cycle, the
// later stages read the sine table, run the single
// 17 x 32 bit multiplier that all shapes share, and scale, round and
// saturate the product into the output register. Each stage holds only when
// the stage after it is full and stalled, so ticks keep being accepted while
// a sample waits on rsp_ready until all four stages are full. Configuration
// is written through the csr_ channel, which is always ready; it should only
// be written while no sample is outstanding.
module multi_shape_waveform_generator_top
   import msw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [17:0]     rsp_sample,
   output logic                   rsp_block_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SINE_MUL_W = 30 + SINE_IDX_W;

   msw_cfg_type cfg;
   logic [16:0] amp_eff;

   msw_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Amplitudes above full scale are clamped before use.
   assign amp_eff = cfg.amplitude[16] ? FULL_Q16 : cfg.amplitude;

   // Pipeline flow control: a stage may load when it is empty or when the
   // stage after it is moving on.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en4;
   logic accept;

   assign en4       = !rsp_valid_ff || rsp_ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign accept    = req_valid && en1;
   assign rsp_valid = rsp_valid_ff;

   // Generator state.
   logic [31:0]             phase_ff, phase_in;
   logic [15:0]             saw_ff, saw_in;
   logic [16:0]             tri_ff, tri_in;
   logic                    rising_ff, rising_in;
   logic [SAMPLE_IDX_W-1:0] index_ff, index_in;

   // State as seen by this tick, after restart and the wrap and clamp rules.
   logic [31:0]             phase_r;
   logic [15:0]             saw_r, saw_e;
   logic [16:0]             tri_r, tri_e;
   logic                    rising_r, rising_e;
   logic [SAMPLE_IDX_W-1:0] index_r;
   logic                    last_e;
   logic [SINE_MUL_W-1:0]   sine_pos;
   logic [SINE_IDX_W-1:0]   sine_i;

   always_comb begin
      phase_r  = req_restart ? 32'd0 : phase_ff;
      saw_r    = req_restart ? 16'd0 : saw_ff;
      tri_r    = req_restart ? TRI_FRESH : tri_ff;
      rising_r = req_restart ? 1'b0 : rising_ff;
      index_r  = req_restart ? '0 : index_ff;

      // A sawtooth count at or beyond the length restarts from zero.
      saw_e = (saw_r >= cfg.saw_length) ? 16'd0 : saw_r;

      // A triangle count above the turning point is pulled back and turns down.
      if (tri_r > {1'b0, cfg.half_period}) begin
         tri_e    = {1'b0, cfg.half_period};
         rising_e = 1'b0;
      end else begin
         tri_e    = tri_r;
         rising_e = rising_r;
      end

      last_e = (index_r == SAMPLE_IDX_W'(SAMPLE_LENGTH - 1));

      phase_in = phase_r + cfg.phase_step;
      saw_in   = saw_e + 16'd1;
      if (rising_e) begin
         tri_in    = tri_e + 17'd1;
         rising_in = 1'b1;
      end else if (tri_e == 17'd0) begin
         // The bottom is held for a second tick before the count turns up.
         tri_in    = tri_e;
         rising_in = 1'b1;
      end else begin
         tri_in    = tri_e - 17'd1;
         rising_in = 1'b0;
      end
      index_in = last_e ? '0 : index_r + 1'b1;

      // Table position within the quadrant.
      sine_pos = SINE_MUL_W'(phase_r[29:0]) * SINE_MUL_W'(SINE_TABLE_DEPTH);
      sine_i   = sine_pos[SINE_MUL_W-1:30];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 32'd0;
         saw_ff    <= 16'd0;
         tri_ff    <= TRI_FRESH;
         rising_ff <= 1'b0;
         index_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         saw_ff    <= saw_in;
         tri_ff    <= tri_in;
         rising_ff <= rising_in;
         index_ff  <= index_in;
      end
   end

   // Stage 1: table address, ramp multiplicand, sign and block flag.
   logic [SINE_IDX_W-1:0] s1_rom_idx_ff, s1_rom_idx_in;
   logic [16:0]           s1_ramp_ff, s1_ramp_in;
   logic                  s1_neg_ff, s1_neg_in;
   logic                  s1_last_ff, s1_last_in;

   always_comb begin
      // Odd quadrants read the table backwards; the upper half is negated.
      s1_rom_idx_in = phase_r[30] ? SINE_IDX_W'(SINE_TABLE_DEPTH) - sine_i : sine_i;
      s1_neg_in     = phase_r[31];
      // The triangle uses twice its count; it never exceeds the 16-bit half period here.
      s1_ramp_in    = (cfg.wave_shape == SHAPE_TRI) ? {tri_e[15:0], 1'b0} : {1'b0, saw_e};
      s1_last_in    = last_e;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_rom_idx_ff <= s1_rom_idx_in;
         s1_ramp_ff    <= s1_ramp_in;
         s1_neg_ff     <= s1_neg_in;
         s1_last_ff    <= s1_last_in;
      end
   end

   // Stage 2: table read and multiplier operand selection.
   logic [16:0] s2_op_a_ff, s2_op_a_in;
   logic [31:0] s2_op_b_ff, s2_op_b_in;
   logic        s2_neg_ff, s2_last_ff;
   logic [16:0] sine_t;

   always_comb begin
      sine_t = SINE_ROM[s1_rom_idx_ff];
      if (cfg.wave_shape == SHAPE_SINE) begin
         s2_op_a_in = amp_eff;
         s2_op_b_in = {15'd0, sine_t};
      end else begin
         s2_op_a_in = s1_ramp_ff;
         s2_op_b_in = cfg.slope;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_op_a_ff <= s2_op_a_in;
         s2_op_b_ff <= s2_op_b_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // Stage 3: the shared multiplier.
   logic [48:0] s3_prod_ff, s3_prod_in;
   logic        s3_neg_ff, s3_last_ff;

   assign s3_prod_in = 49'(s2_op_a_ff) * 49'(s2_op_b_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_prod_ff <= s3_prod_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // Stage 4: scale to Q0, subtract the offset, round toward zero, saturate.
   logic signed [17:0] rsp_sample_ff, rsp_sample_in;
   logic               rsp_last_ff;
   logic signed [34:0] ramp_diff;
   logic signed [34:0] ramp_trunc;
   logic signed [17:0] ramp_sample;
   logic [16:0]        sine_mag;

   always_comb begin
      // The offset has no fraction, so the product's fraction decides rounding.
      ramp_diff = $signed({2'b00, s3_prod_ff[48:16]}) - $signed({18'd0, amp_eff});
      if (ramp_diff < 0 && s3_prod_ff[15:0] != 16'd0) begin
         ramp_trunc = ramp_diff + 35'sd1;
      end else begin
         ramp_trunc = ramp_diff;
      end
      if (ramp_trunc > 35'sd65536) begin
         ramp_sample = 18'sd65536;
      end else if (ramp_trunc < -35'sd65536) begin
         ramp_sample = -18'sd65536;
      end else begin
         ramp_sample = ramp_trunc[17:0];
      end

      sine_mag = s3_prod_ff[32:16];

      case (cfg.wave_shape) inside
         SHAPE_SINE: begin
            rsp_sample_in = s3_neg_ff ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
         end
         SHAPE_SAW, SHAPE_TRI: rsp_sample_in = ramp_sample;
         default:              rsp_sample_in = 18'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_last_ff   <= s3_last_ff;
      end
   end

   assign rsp_sample     = rsp_sample_ff;
   assign rsp_block_last = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= accept;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) rsp_valid_ff <= s3_valid_ff;
      end
   end

endmodule

>>> test/msw_sample_checker.sv
// Checker for the waveform generator: predicts every sample and compares the rsp_ transfers.
`timescale 1ns / 100ps
module msw_sample_checker
   import msw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_restart,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic signed [17:0]     rsp_sample,
   input  logic                   rsp_block_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     outstanding
);

   typedef struct packed {
      logic signed [17:0] sample;
      logic               block_last;
   } wave_sample_type;

   localparam longint FULL_SCALE = 65536;

   msw_cfg_type     cfg;
   int unsigned     sample_count;
   logic [31:0]     phase;
   logic [15:0]     saw_count;
   logic [16:0]     tri_count;
   logic            tri_rising;
   logic [16:0]     quarter_sine [SINE_TABLE_DEPTH + 1];
   wave_sample_type expected_samples [$];

   task automatic restore_defaults();
      cfg.wave_shape  = SHAPE_SINE;
      cfg.amplitude   = '0;
      cfg.phase_step  = '0;
      cfg.saw_length  = 16'd1;
      cfg.half_period = '0;
      cfg.slope       = '0;
      sample_count    = 0;
      phase           = '0;
      saw_count       = '0;
      tri_count       = TRI_FRESH;
      tri_rising      = 1'b0;
      expected_samples.delete();
   endtask

   task automatic flag_error(input string what);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Sawtooth and triangle share this: the product of a count and the Q16.16 slope, less the amplitude, truncated
   // towards zero and saturated to full scale.
   function automatic longint ramp_level(input logic [63:0] product, input logic [16:0] amp);
      longint level;
      level = (longint'(product) - longint'(amp) * FULL_SCALE) / FULL_SCALE;
      if (level > FULL_SCALE) begin
         level = FULL_SCALE;
      end else if (level < -FULL_SCALE) begin
         level = -FULL_SCALE;
      end
      return level;
   endfunction

   function automatic longint sine_level(input logic [16:0] amp);
      int unsigned idx;
      logic [16:0] entry;
      logic [63:0] mag;
      idx   = 32'((64'(phase[29:0]) * 64'(SINE_TABLE_DEPTH)) >> 30);
      entry = phase[30] ? quarter_sine[SINE_TABLE_DEPTH - idx] : quarter_sine[idx];
      mag   = (64'(amp) * 64'(entry)) >> 16;
      return phase[31] ? -longint'(mag) : longint'(mag);
   endfunction

   // One tick: works out the sample and moves every generator on, whatever the shape.
   function automatic wave_sample_type next_sample(input logic restart);
      logic [16:0]     amp;
      longint          saw_level;
      longint          tri_level;
      longint          level;
      wave_sample_type result;
      amp = (cfg.amplitude > FULL_Q16) ? FULL_Q16 : cfg.amplitude;
      if (restart) begin
         phase        = '0;
         saw_count    = '0;
         tri_count    = TRI_FRESH;
         tri_rising   = 1'b0;
         sample_count = 0;
      end
      if (saw_count >= cfg.saw_length) begin
         saw_count = '0;
      end
      saw_level = ramp_level(64'(saw_count) * 64'(cfg.slope), amp);
      if (tri_count > 17'(cfg.half_period)) begin
         tri_count  = 17'(cfg.half_period);
         tri_rising = 1'b0;
      end
      tri_level = ramp_level(64'(tri_count) * 64'(cfg.slope) * 64'd2, amp);
      case (cfg.wave_shape)
         SHAPE_SINE: level = sine_level(amp);
         SHAPE_SAW:  level = saw_level;
         SHAPE_TRI:  level = tri_level;
         default:    level = 0;
      endcase
      result.sample     = level[17:0];
      result.block_last = (sample_count >= SAMPLE_LENGTH - 1);

      phase     = phase + cfg.phase_step;
      saw_count = saw_count + 16'd1;
      if (tri_rising) begin
         tri_count = tri_count + 17'd1;
      end else if (tri_count == '0) begin
         tri_rising = 1'b1;
      end else begin
         tri_count = tri_count - 17'd1;
      end
      sample_count = result.block_last ? 0 : sample_count + 1;
      return result;
   endfunction

   // Quarter-wave table from a nine-term Taylor series in Q30, rounded to Q16.
   initial begin
      logic [63:0] angle;
      logic [63:0] power;
      logic [63:0] acc;
      logic [63:0] rounded;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         angle = (64'(k) * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
         power = angle;
         acc   = angle;
         for (int n = 1; n <= 8; n++) begin
            power = (((power * angle) >> 30) * angle) >> 30;
            power = power / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
               acc = (acc > power) ? acc - power : 64'd0;
            end else begin
               acc = acc + power;
            end
         end
         rounded = (acc + 64'd8192) >> 14;
         quarter_sine[k] = (rounded > 64'(FULL_Q16)) ? FULL_Q16 : rounded[16:0];
      end
      fail_count  = 0;
      outstanding = 0;
      restore_defaults();
   end

   always @(posedge clock) begin
      wave_sample_type want;
      if (reset) begin
         restore_defaults();
      end else begin
         // Results are retired before this edge's tick is queued, so a sample
         // that arrives with nothing outstanding is never hidden.
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               flag_error($sformatf("unexpected sample %0d last %0b",
                                    rsp_sample, rsp_block_last));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want.sample || rsp_block_last !== want.block_last) begin
                  flag_error($sformatf("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                       $signed(want.sample), want.block_last,
                                       rsp_sample, rsp_block_last));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WAVE_SHAPE:  cfg.wave_shape  = shape_type'(csr_data[1:0]);
               CSR_AMPLITUDE:   cfg.amplitude   = csr_data[16:0];
               CSR_PHASE_STEP:  cfg.phase_step  = csr_data;
               CSR_SAW_LENGTH:  cfg.saw_length  = csr_data[15:0];
               CSR_HALF_PERIOD: cfg.half_period = csr_data[15:0];
               CSR_SLOPE:       cfg.slope       = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_samples.push_back(next_sample(req_restart));
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

>>> test/tb.sv
// Testbench top for the waveform generator: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps
module tb;
   import msw_pkg::*;

   // Settling time after the last sample.
   localparam int DRAIN_CYCLES      = 8;
   localparam int RANDOM_SETTINGS   = 12;
   localparam int TICKS_PER_SETTING = 125;
   localparam int TIMEOUT_NS        = 400000;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic signed [17:0]     rsp_sample;
   logic                   rsp_block_last;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   int fail_count;
   int outstanding;

   // Idling controls: percentage of cycles in which the sender holds back and
   // the receiver stalls, and the chance of a restart on a random tick.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int restart_pct    = 0;

   multi_shape_waveform_generator_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_block_last (rsp_block_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   msw_sample_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample     (rsp_sample),
      .rsp_block_last (rsp_block_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver decides afresh every cycle whether it will take a sample.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   // Safety net in case the block hangs; far longer than the slowest correct run.
   initial begin
      #(TIMEOUT_NS);
      $display("** multi_shape_waveform_generator_top: FAILED **");
      $finish;
   end

   // One tick on the req_ channel. Valid is lowered only for idle cycles and is
   // then held, with its payload, until the transfer takes place.
   task automatic send_tick(input logic restart);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_ticks(input int count, input logic restart_first);
      for (int i = 0; i < count; i++) begin
         if (i == 0) begin
            send_tick(restart_first);
         end else begin
            send_tick($urandom_range(99, 0) < restart_pct);
         end
      end
   endtask

   // Stops the sender and waits until every sample has been seen, then lets the
   // pipeline settle. Outstanding is sampled on the falling edge, away from the
   // edge at which the checker updates it.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // A register write; valid stays high so that writes can follow back to back.
   task automatic put_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes every register. The bits above each field are filled with random
   // junk, which the block must ignore.
   task automatic write_config(input msw_cfg_type c);
      put_reg(CSR_WAVE_SHAPE,  {30'($urandom()), c.wave_shape});
      put_reg(CSR_AMPLITUDE,   {15'($urandom()), c.amplitude});
      put_reg(CSR_PHASE_STEP,  c.phase_step);
      put_reg(CSR_SAW_LENGTH,  {16'($urandom()), c.saw_length});
      put_reg(CSR_HALF_PERIOD, {16'($urandom()), c.half_period});
      put_reg(CSR_SLOPE,       c.slope);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // A random setting. Short saw lengths and half periods let the counters wrap
   // many times within one setting, and the slope is mostly matched to the
   // amplitude so that the ramps span the full range without saturating.
   function automatic msw_cfg_type random_config();
      msw_cfg_type c;
      int unsigned pick;
      logic [63:0] divisor;
      pick = $urandom_range(9, 0);
      if (pick < 3) begin
         c.wave_shape = SHAPE_SINE;
      end else if (pick < 6) begin
         c.wave_shape = SHAPE_SAW;
      end else if (pick < 9) begin
         c.wave_shape = SHAPE_TRI;
      end else begin
         c.wave_shape = SHAPE_NONE;
      end
      case ($urandom_range(3, 0))
         0:       c.amplitude = FULL_Q16;
         1:       c.amplitude = 17'($urandom_range(17'h1FFFF, 17'h10001));
         2:       c.amplitude = '0;
         default: c.amplitude = 17'($urandom_range(65536, 0));
      endcase
      c.phase_step = $urandom() >> $urandom_range(31, 0);
      case ($urandom_range(7, 0))
         0:       c.saw_length = '0;
         1:       c.saw_length = '1;
         default: c.saw_length = 16'($urandom_range(150, 1));
      endcase
      case ($urandom_range(7, 0))
         0:       c.half_period = '0;
         1:       c.half_period = '1;
         default: c.half_period = 16'($urandom_range(50, 0));
      endcase
      if ($urandom_range(3, 0) == 0) begin
         c.slope = $urandom() >> $urandom_range(31, 0);
      end else begin
         divisor = (c.wave_shape == SHAPE_SAW) ? 64'(c.saw_length) : 64'(c.half_period);
         if (divisor == 0) begin
            divisor = 64'd1;
         end
         if (c.wave_shape == SHAPE_SAW) begin
            c.slope = 32'((64'(c.amplitude) << 17) / divisor) + $urandom_range(3, 0);
         end else begin
            c.slope = 32'((64'(c.amplitude) << 16) / divisor) + $urandom_range(3, 0);
         end
      end
      return c;
   endfunction

   initial begin
      msw_cfg_type cfg;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with no idling on either side.
      set_idling(0, 0);

      // The reset setting: sine at zero amplitude.
      run_ticks(1, 1'b0);
      drain_results();

      // Triangle with a half period of two and an amplitude above range: both
      // turning points are held for two ticks and the peaks just reach full scale.
      write_config('{wave_shape: SHAPE_TRI, amplitude: 17'h1FFFF, phase_step: 32'd0,
                     saw_length: 16'd1, half_period: 16'd2, slope: 32'h8000_0000});
      run_ticks(7, 1'b1);
      drain_results();

      // Sawtooth with the largest slope saturates at full scale.
      write_config('{wave_shape: SHAPE_SAW, amplitude: 17'd0, phase_step: 32'hFFFF_FFFF,
                     saw_length: 16'd3, half_period: 16'hFFFF, slope: 32'hFFFF_FFFF});
      run_ticks(3, 1'b1);
      drain_results();

      // A zero saw length keeps the counter at zero.
      write_config('{wave_shape: SHAPE_SAW, amplitude: 17'd1000, phase_step: 32'd0,
                     saw_length: 16'd0, half_period: 16'd0, slope: 32'hFFFF_FFFF});
      run_ticks(2, 1'b0);
      drain_results();

      // A slow ramp at unit slope, then a shorter length with the counter
      // already beyond it, so the counter wraps before use.
      write_config('{wave_shape: SHAPE_SAW, amplitude: 17'h1FFFF, phase_step: 32'd0,
                     saw_length: 16'hFFFF, half_period: 16'd0, slope: 32'h0001_0000});
      run_ticks(4, 1'b1);
      drain_results();
      write_config('{wave_shape: SHAPE_SAW, amplitude: 17'h1FFFF, phase_step: 32'd0,
                     saw_length: 16'd2, half_period: 16'd0, slope: 32'h0001_0000});
      run_ticks(2, 1'b0);
      drain_results();

      // Sine in quarter-cycle steps visits every quadrant boundary.
      write_config('{wave_shape: SHAPE_SINE, amplitude: FULL_Q16, phase_step: 32'h4000_0000,
                     saw_length: 16'd1, half_period: 16'd0, slope: 32'd0});
      run_ticks(5, 1'b1);
      drain_results();

      // The unused shape code gives silence.
      write_config('{wave_shape: SHAPE_NONE, amplitude: FULL_Q16, phase_step: 32'h1234_5678,
                     saw_length: 16'd5, half_period: 16'd5, slope: 32'h0001_0000});
      run_ticks(1, 1'b1);
      drain_results();

      // Random part: a fresh setting each time, cycling through the idling
      // phases. The first two settings push every field but the shape to its top or bottom.
      restart_pct = 4;
      for (int s = 0; s < RANDOM_SETTINGS; s++) begin
         cfg = random_config();
         if (s == 0) begin
            cfg.amplitude   = '1;
            cfg.phase_step  = '1;
            cfg.saw_length  = '1;
            cfg.half_period = '1;
            cfg.slope       = '1;
         end else if (s == 1) begin
            cfg.amplitude   = '0;
            cfg.phase_step  = '0;
            cfg.saw_length  = '0;
            cfg.half_period = '0;
            cfg.slope       = '0;
         end
         write_config(cfg);
         case (s % 4)
            0:       set_idling(0, 0);
            1:       set_idling(81, 0);
            2:       set_idling(0, 81);
            default: set_idling(8, 8);
         endcase
         run_ticks(TICKS_PER_SETTING, 1'($urandom_range(1, 0)));
         drain_results();
      end

      @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** multi_shape_waveform_generator_top: PASSED **");
      end else begin
         $display("** multi_shape_waveform_generator_top: FAILED **");
      end
      $finish;
   end

endmodule
